/* sv/fpa_pkg.sv */
package fpa_pkg;

  localparam logic [3:0] MODE_ADD      = 4'd0;
  localparam logic [3:0] MODE_SUB      = 4'd1;
  localparam logic [3:0] MODE_MUL      = 4'd2;
  localparam logic [3:0] MODE_DIV      = 4'd3;
  localparam logic [3:0] MODE_CMP      = 4'd4;
  localparam logic [3:0] MODE_MIN      = 4'd5;
  localparam logic [3:0] MODE_MAX      = 4'd6;
  localparam logic [3:0] MODE_INC      = 4'd7;
  localparam logic [3:0] MODE_DEC      = 4'd8;
  localparam logic [3:0] MODE_TO_INT   = 4'd9;
  localparam logic [3:0] MODE_FROM_INT = 4'd10;

  localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [31:0] NEG_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [3:0]         mode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } fpa_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               a_less;
    logic               a_equal;
    logic               a_greater;
    logic               div_by_zero;
    logic               overflow;
  } fpa_out_t;

  // Per-word status that rides along the pipeline
  typedef struct packed {
    logic [3:0]  mode;
    logic        neg;
    logic [31:0] result;
    logic        lt;
    logic        eq;
    logic        gt;
    logic        dz;
    logic        ovf;
  } fpa_side_t;

  typedef struct packed {
    logic [31:0] value;
    logic        ovf;
  } fpa_res_t;

  // Apply sign to a magnitude and clamp to the signed 32-bit range
  function automatic fpa_res_t fpa_signed_sat(input logic [63:0] mag, input logic neg);
    fpa_res_t    res;
    logic [63:0] limit;
    limit = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7fff_ffff;
    if (mag > limit) begin
      res.ovf   = 1'b1;
      res.value = neg ? NEG_MIN : POS_MAX;
    end else begin
      res.ovf   = 1'b0;
      res.value = neg ? (32'd0 - mag[31:0]) : mag[31:0];
    end
    return res;
  endfunction

  // Clamp a 33-bit signed sum to 32 bits
  function automatic fpa_res_t fpa_sat33(input logic [32:0] x);
    fpa_res_t res;
    if (x[32] != x[31]) begin
      res.ovf   = 1'b1;
      res.value = x[32] ? NEG_MIN : POS_MAX;
    end else begin
      res.ovf   = 1'b0;
      res.value = x[31:0];
    end
    return res;
  endfunction

endpackage

/* sv/fpa_front.sv */
module fpa_front #(
  parameter int FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              in_valid,
  input  fpa_pkg::fpa_in_t  in_data,
  output logic              v_o,
  output fpa_pkg::fpa_side_t side_o,
  output logic [31:0]       mag_a_o,
  output logic [31:0]       mag_b_o
);
  import fpa_pkg::*;

  localparam int FW = 32 + FRAC_BITS;

  logic signed [31:0] a;
  logic signed [31:0] b;
  logic [32:0]        sum;
  logic [32:0]        dif;
  logic [32:0]        incv;
  logic [32:0]        decv;
  logic [FW-1:0]      wide;
  logic               fi_ovf;
  fpa_res_t           sat;
  fpa_side_t          side_nxt;
  logic [31:0]        mag_a_nxt;
  logic [31:0]        mag_b_nxt;

  logic               v_r;
  fpa_side_t          side_r;
  logic [31:0]        mag_a_r;
  logic [31:0]        mag_b_r;

  assign a = in_data.operand_a;
  assign b = in_data.operand_b;

  always_comb begin
    sum    = {a[31], a} + {b[31], b};
    dif    = {a[31], a} - {b[31], b};
    incv   = {a[31], a} + 33'd1;
    decv   = {a[31], a} - 33'd1;
    wide   = {{FRAC_BITS{a[31]}}, a} << FRAC_BITS;
    fi_ovf = (wide[FW-1:31] != {(FRAC_BITS + 1){a[31]}});
    sat    = '0;

    side_nxt.mode   = in_data.mode;
    side_nxt.neg    = a[31] ^ b[31];
    side_nxt.lt     = (a < b);
    side_nxt.eq     = (a == b);
    side_nxt.gt     = (a > b);
    side_nxt.dz     = 1'b0;
    side_nxt.ovf    = 1'b0;
    side_nxt.result = '0;

    case (in_data.mode)
      MODE_ADD: begin
        sat = fpa_sat33(sum);
        side_nxt.result = sat.value;
        side_nxt.ovf    = sat.ovf;
      end
      MODE_SUB: begin
        sat = fpa_sat33(dif);
        side_nxt.result = sat.value;
        side_nxt.ovf    = sat.ovf;
      end
      MODE_DIV: side_nxt.dz = (b == 32'sd0);
      MODE_MIN: side_nxt.result = (a < b) ? a : b;
      MODE_MAX: side_nxt.result = (a > b) ? a : b;
      MODE_INC: begin
        sat = fpa_sat33(incv);
        side_nxt.result = sat.value;
        side_nxt.ovf    = sat.ovf;
      end
      MODE_DEC: begin
        sat = fpa_sat33(decv);
        side_nxt.result = sat.value;
        side_nxt.ovf    = sat.ovf;
      end
      MODE_TO_INT: side_nxt.result = a >>> FRAC_BITS;
      MODE_FROM_INT: begin
        side_nxt.ovf    = fi_ovf;
        side_nxt.result = fi_ovf ? (a[31] ? NEG_MIN : POS_MAX) : wide[31:0];
      end
      default: side_nxt.result = '0;
    endcase

    mag_a_nxt = a[31] ? (32'd0 - $unsigned(a)) : $unsigned(a);
    mag_b_nxt = b[31] ? (32'd0 - $unsigned(b)) : $unsigned(b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (load) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      side_r  <= side_nxt;
      mag_a_r <= mag_a_nxt;
      mag_b_r <= mag_b_nxt;
    end
  end

  assign v_o     = v_r;
  assign side_o  = side_r;
  assign mag_a_o = mag_a_r;
  assign mag_b_o = mag_b_r;

endmodule

/* sv/fpa_mul.sv */
module fpa_mul #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               v_i,
  input  fpa_pkg::fpa_side_t side_i,
  input  logic [31:0]        mag_a_i,
  input  logic [31:0]        mag_b_i,
  output logic               v_o,
  output fpa_pkg::fpa_side_t side_o,
  output logic [31:0]        mag_a_o,
  output logic [31:0]        mag_b_o
);
  import fpa_pkg::*;

  logic        v1_r;
  logic [63:0] prod_r;
  fpa_side_t   side1_r;
  logic [31:0] mag_a1_r;
  logic [31:0] mag_b1_r;

  logic        v2_r;
  fpa_side_t   side2_r;
  logic [31:0] mag_a2_r;
  logic [31:0] mag_b2_r;

  logic [63:0] rnd;
  logic [63:0] mag;
  fpa_res_t    res;
  fpa_side_t   side2_nxt;

  // Round half up on the magnitude, then restore the sign
  always_comb begin
    rnd       = prod_r + (64'd1 << (FRAC_BITS - 1));
    mag       = rnd >> FRAC_BITS;
    res       = fpa_signed_sat(mag, side1_r.neg);
    side2_nxt = side1_r;
    if (side1_r.mode == MODE_MUL) begin
      side2_nxt.result = res.value;
      side2_nxt.ovf    = res.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= 64'(mag_a_i) * 64'(mag_b_i);
      side1_r  <= side_i;
      mag_a1_r <= mag_a_i;
      mag_b1_r <= mag_b_i;
      side2_r  <= side2_nxt;
      mag_a2_r <= mag_a1_r;
      mag_b2_r <= mag_b1_r;
    end
  end

  assign v_o     = v2_r;
  assign side_o  = side2_r;
  assign mag_a_o = mag_a2_r;
  assign mag_b_o = mag_b2_r;

endmodule

/* sv/fpa_div.sv */
module fpa_div #(
  parameter int FRAC_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      v_i,
  input  fpa_pkg::fpa_side_t        side_i,
  input  logic [31:0]               mag_a_i,
  input  logic [31:0]               mag_b_i,
  output logic                      v_o,
  output fpa_pkg::fpa_side_t        side_o,
  output logic [32+FRAC_BITS-1:0]   quot_o,
  output logic [31:0]               rem_o,
  output logic [31:0]               den_o
);
  import fpa_pkg::*;

  localparam int NW = 32 + FRAC_BITS;

  logic [NW-1:0] v_r;
  logic [31:0]   rem_r  [NW];
  logic [NW-1:0] nq_r   [NW];
  logic [31:0]   den_r  [NW];
  fpa_side_t     side_r [NW];

  // One restoring step per stage: numerator bits shift out the top of nq,
  // quotient bits shift in at the bottom
  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [31:0]   rem_in;
    logic [NW-1:0] nq_in;
    logic [31:0]   den_in;
    fpa_side_t     side_in;
    logic [32:0]   trial;
    logic          ge;
    logic [31:0]   rem_nxt;
    logic [NW-1:0] nq_nxt;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign nq_in   = {mag_a_i, {FRAC_BITS{1'b0}}};
      assign den_in  = mag_b_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign nq_in   = nq_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      trial   = {rem_in, nq_in[NW-1]};
      ge      = (trial >= {1'b0, den_in});
      rem_nxt = ge ? 32'(trial - {1'b0, den_in}) : trial[31:0];
      nq_nxt  = {nq_in[NW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        nq_r[k]   <= nq_nxt;
        den_r[k]  <= den_in;
        side_r[k] <= side_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NW-2:0], v_i};
    end
  end

  assign v_o    = v_r[NW-1];
  assign side_o = side_r[NW-1];
  assign quot_o = nq_r[NW-1];
  assign rem_o  = rem_r[NW-1];
  assign den_o  = den_r[NW-1];

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NW-1] && (den_r[NW-1] != 32'd0) |-> rem_r[NW-1] < den_r[NW-1])
    else $error("divider remainder not below divisor");

endmodule

/* sv/fpa_back.sv */
module fpa_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    v_i,
  input  fpa_pkg::fpa_side_t      side_i,
  input  logic [32+FRAC_BITS-1:0] quot_i,
  input  logic [31:0]             rem_i,
  input  logic [31:0]             den_i,
  output logic                    out_valid,
  output fpa_pkg::fpa_out_t       out_data
);
  import fpa_pkg::*;

  localparam int NW = 32 + FRAC_BITS;
  localparam int MW = NW + 1;

  logic          up;
  logic [MW-1:0] m_nxt;
  logic          v1_r;
  logic [MW-1:0] m_r;
  fpa_side_t     side1_r;

  fpa_res_t      res;
  fpa_out_t      out_nxt;
  logic          out_v_r;
  fpa_out_t      out_r;

  // Round to nearest: bump when twice the remainder reaches the divisor
  always_comb begin
    up    = ({rem_i, 1'b0} >= {1'b0, den_i});
    m_nxt = {1'b0, quot_i} + MW'(up);
  end

  always_comb begin
    res                  = fpa_signed_sat(64'(m_r), side1_r.neg);
    out_nxt.result_value = side1_r.result;
    out_nxt.overflow     = side1_r.ovf;
    out_nxt.a_less       = side1_r.lt;
    out_nxt.a_equal      = side1_r.eq;
    out_nxt.a_greater    = side1_r.gt;
    out_nxt.div_by_zero  = side1_r.dz;
    if ((side1_r.mode == MODE_DIV) && !side1_r.dz) begin
      out_nxt.result_value = res.value;
      out_nxt.overflow     = res.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v1_r    <= v_i;
      out_v_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r     <= m_nxt;
      side1_r <= side_i;
      out_r   <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

/* sv/fixed_point_alu_top.sv */
// Channel  Ports                          Direction  Word
// in       in_valid, in_ready, in_data    input      fpa_in_t  (mode, operand_a, operand_b)
// out      out_valid, out_ready, out_data output     fpa_out_t (result_value, flags)
//
// One word enters per cycle while in_ready is high; the divider resolves one
// quotient bit per stage over 32 + FRAC_BITS stages.
// Every mode takes the same path, so results leave in input order.
// Reset (rst_n low, synchronous) clears all valid bits; payload is not reset.
// A stalled output freezes the whole pipeline; an empty first stage still loads.
module fixed_point_alu_top #(
  parameter int FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fpa_pkg::fpa_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fpa_pkg::fpa_out_t out_data
);
  import fpa_pkg::*;

  localparam int NW = 32 + FRAC_BITS;

  logic          en;
  logic          front_load;

  logic          front_v;
  fpa_side_t     front_side;
  logic [31:0]   front_mag_a;
  logic [31:0]   front_mag_b;

  logic          mul_v;
  fpa_side_t     mul_side;
  logic [31:0]   mul_mag_a;
  logic [31:0]   mul_mag_b;

  logic          div_v;
  fpa_side_t     div_side;
  logic [NW-1:0] div_quot;
  logic [31:0]   div_rem;
  logic [31:0]   div_den;

  // Advance everything unless a finished word is held at the output
  assign en         = !out_valid || out_ready;
  assign front_load = en || !front_v;
  assign in_ready   = front_load;

  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (front_load),
    .in_valid (in_valid),
    .in_data  (in_data),
    .v_o      (front_v),
    .side_o   (front_side),
    .mag_a_o  (front_mag_a),
    .mag_b_o  (front_mag_b)
  );

  fpa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_i     (front_v),
    .side_i  (front_side),
    .mag_a_i (front_mag_a),
    .mag_b_i (front_mag_b),
    .v_o     (mul_v),
    .side_o  (mul_side),
    .mag_a_o (mul_mag_a),
    .mag_b_o (mul_mag_b)
  );

  fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_i     (mul_v),
    .side_i  (mul_side),
    .mag_a_i (mul_mag_a),
    .mag_b_i (mul_mag_b),
    .v_o     (div_v),
    .side_o  (div_side),
    .quot_o  (div_quot),
    .rem_o   (div_rem),
    .den_o   (div_den)
  );

  fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .v_i       (div_v),
    .side_i    (div_side),
    .quot_i    (div_quot),
    .rem_i     (div_rem),
    .den_i     (div_den),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_data.a_less, out_data.a_equal, out_data.a_greater}))
    else $error("compare flags not one-hot");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.div_by_zero |->
      (out_data.result_value == 32'sd0) && !out_data.overflow)
    else $error("divide by zero word carries a result or overflow");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |->
      (out_data.result_value == POS_MAX) || (out_data.result_value == NEG_MIN))
    else $error("overflow word not at a range end");

endmodule

/* tb/fixed_point_alu_top_tb.sv */
module fixed_point_alu_top_tb;
  import fpa_pkg::*;

  localparam int FRAC = 8;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_WORDS = 700;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  fpa_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  fpa_out_t out_data;

  fpa_in_t  operand_words[$];
  fpa_out_t predicted_results[$];

  int error_count = 0;
  int sent_count = 0;
  int results_seen = 0;
  int saturated_seen = 0;
  int div_zero_seen = 0;
  int mode_hits[16];
  int send_gap = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  fixed_point_alu_top #(.FRAC_BITS(FRAC)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  function automatic fpa_out_t alu_predict(input fpa_in_t w);
    fpa_out_t res;
    longint   a;
    longint   b;
    longint   r;
    longint   m;
    longint   den;
    bit       neg;
    a = $signed(w.operand_a);
    b = $signed(w.operand_b);
    r = 0;
    neg = (a < 0) != (b < 0);
    res = '0;
    case (w.mode)
      MODE_ADD: r = a + b;
      MODE_SUB: r = a - b;
      MODE_MUL: begin
        m = a * b;
        if (m < 0) m = -m;
        m = (m + (longint'(1) << (FRAC - 1))) >> FRAC;
        r = neg ? -m : m;
      end
      MODE_DIV: begin
        if (b == 0) begin
          res.div_by_zero = 1'b1;
        end else begin
          m = ((a < 0) ? -a : a) << FRAC;
          den = (b < 0) ? -b : b;
          m = (2 * m + den) / (2 * den);
          r = neg ? -m : m;
        end
      end
      MODE_MIN: r = (a < b) ? a : b;
      MODE_MAX: r = (a > b) ? a : b;
      MODE_INC: r = a + 1;
      MODE_DEC: r = a - 1;
      MODE_TO_INT: r = a >>> FRAC;
      MODE_FROM_INT: r = a * (longint'(1) << FRAC);
      default: r = 0;
    endcase
    if (r > 64'sd2147483647) begin
      r = 64'sd2147483647;
      res.overflow = 1'b1;
    end else if (r < -64'sd2147483648) begin
      r = -64'sd2147483648;
      res.overflow = 1'b1;
    end
    res.result_value = r[31:0];
    res.a_less = a < b;
    res.a_equal = a == b;
    res.a_greater = a > b;
    return res;
  endfunction

  function automatic int draw_wait(input bit calm);
    if (calm || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(0, 6))
      0: v = $urandom_range(0, 4095) - 2048;
      1: v = POS_MAX - $urandom_range(0, 3);
      2: v = NEG_MIN + $urandom_range(0, 3);
      3: v = (32'd1 << $urandom_range(0, 30)) * ($urandom_range(0, 1) ? 32'd1 : -32'd1);
      4: v = {{11{$urandom_range(0, 1) == 1}}, 21'($urandom)};
      5: v = $urandom_range(0, 3) - 1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic queue_word(input logic [3:0] mode, input logic [31:0] a, input logic [31:0] b);
    operand_words.push_back(fpa_in_t'{mode, a, b});
  endtask

  task automatic compare_field(input string name, input logic signed [63:0] exp_v,
                               input logic signed [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_results.push_back(alu_predict(in_data));
        mode_hits[in_data.mode]++;
        sent_count++;
      end
      if (in_valid && !in_ready) begin
        // hold the word until taken
      end else if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (operand_words.size() != 0) begin
        in_data <= operand_words.pop_front();
        in_valid <= 1'b1;
        send_gap <= draw_wait(((sent_count / 50) % 4) == 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    fpa_out_t exp_word;
    int       w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $error("result word with nothing pending: value %0d", $signed(out_data.result_value));
          error_count++;
        end else begin
          exp_word = predicted_results.pop_front();
          compare_field("result_value", $signed(exp_word.result_value),
                        $signed(out_data.result_value));
          compare_field("a_less", exp_word.a_less, out_data.a_less);
          compare_field("a_equal", exp_word.a_equal, out_data.a_equal);
          compare_field("a_greater", exp_word.a_greater, out_data.a_greater);
          compare_field("div_by_zero", exp_word.div_by_zero, out_data.div_by_zero);
          compare_field("overflow", exp_word.overflow, out_data.overflow);
          saturated_seen += exp_word.overflow;
          div_zero_seen += exp_word.div_by_zero;
        end
        results_seen++;
        // back up the pipeline once so the input side stalls
        w = (results_seen == 150) ? LONG_HOLD : draw_wait(((results_seen / 64) % 4) == 1);
        stall_left <= w;
        out_ready <= (w == 0);
      end else if (stall_left > 1) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        stall_left <= 0;
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("fixed_point_alu_top_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [3:0]  mode;
    logic [31:0] a;
    logic [31:0] b;
    int          total_words;

    queue_word(MODE_ADD, POS_MAX, 32'd1);
    queue_word(MODE_ADD, NEG_MIN, -32'sd1);
    queue_word(MODE_SUB, NEG_MIN, 32'd1);
    queue_word(MODE_SUB, POS_MAX, NEG_MIN);
    // half-LSB products and quotients round away from zero
    queue_word(MODE_MUL, 32'd1, 32'd128);
    queue_word(MODE_MUL, -32'sd1, 32'd128);
    queue_word(MODE_MUL, POS_MAX, POS_MAX);
    queue_word(MODE_MUL, NEG_MIN, NEG_MIN);
    queue_word(MODE_MUL, NEG_MIN, POS_MAX);
    queue_word(MODE_DIV, 32'd1, 32'd512);
    queue_word(MODE_DIV, -32'sd1, 32'd512);
    queue_word(MODE_DIV, 32'd1234, 32'd0);
    queue_word(MODE_DIV, NEG_MIN, 32'd1);
    queue_word(MODE_DIV, NEG_MIN, -32'sd1);
    queue_word(MODE_CMP, 32'd77, 32'd77);
    queue_word(MODE_MIN, -32'sd5, -32'sd5);
    queue_word(MODE_MAX, NEG_MIN, POS_MAX);
    queue_word(MODE_INC, POS_MAX, 32'd0);
    queue_word(MODE_DEC, NEG_MIN, 32'd0);
    queue_word(MODE_TO_INT, -32'sd1, 32'd0);
    queue_word(MODE_TO_INT, NEG_MIN, POS_MAX);
    queue_word(MODE_FROM_INT, POS_MAX, 32'd0);
    queue_word(MODE_FROM_INT, NEG_MIN, 32'd0);
    queue_word(MODE_FROM_INT, -32'sd3, 32'd9);
    queue_word(4'd15, 32'd3, -32'sd3);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      mode = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(11, 15))
                                          : 4'($urandom_range(0, 10));
      a = pick_operand();
      b = ($urandom_range(0, 7) == 0) ? a : pick_operand();
      queue_word(mode, a, b);
    end
    total_words = operand_words.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (results_seen < total_words)
      @(posedge clk);
    // let any stray word surface
    repeat (FRAC + 50) @(posedge clk);

    if (results_seen != total_words || predicted_results.size() != 0) begin
      $error("results_seen: expected %0d, got %0d", total_words, results_seen);
    end

    $display("ran %0d words through all 11 modes and %0d with unused mode codes",
             sent_count, mode_hits[11] + mode_hits[12] + mode_hits[13] + mode_hits[14]
             + mode_hits[15]);
    $display("%0d results checked, %0d saturated, %0d divide-by-zero",
             results_seen, saturated_seen, div_zero_seen);
    if (error_count == 0 && results_seen == total_words && predicted_results.size() == 0) begin
      $display("fixed_point_alu_top_tb: clean");
    end else begin
      $display("fixed_point_alu_top_tb: errors");
    end
    $finish;
  end

endmodule
